@@ rtl/core/bmef_pkg.sv @@
// ----------------------------------------------------------------------------
// bmef_pkg
// Shared types and constants of the bitset maximal element filter.
// ----------------------------------------------------------------------------
package bmef_pkg;

  localparam int POINT_W      = 16;
  localparam int DIMS_DEF     = 16;
  localparam int CAPACITY_DEF = 32;

  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic               set_end;
  } in_item_t;

  typedef struct packed {
    logic [POINT_W-1:0] kept_point;
    logic               final_result;
    logic               overflowed;
  } out_item_t;

  // Result of the shared compare unit
  typedef struct packed {
    logic subset;      // ref point is a strict subset of the candidate
    logic above_last;  // candidate > last survivor found
    logic below_best;  // candidate < best found so far in this scan
  } cmp_res_t;

endpackage

@@ rtl/core/bmef_store.sv @@
// ----------------------------------------------------------------------------
// bmef_store
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmef_store #(
  parameter int DEPTH = bmef_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [bmef_pkg::POINT_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [bmef_pkg::POINT_W-1:0] rdata_o
);
  import bmef_pkg::*;

  logic [POINT_W-1:0] mem [DEPTH];
  logic [POINT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bmef_cmp.sv @@
// ----------------------------------------------------------------------------
// bmef_cmp
// Shared compare unit: subset test for the dominance pass, ordering tests
// for the ascending emit scan.
// ----------------------------------------------------------------------------
module bmef_cmp (
  input  logic [bmef_pkg::POINT_W-1:0] ref_i,
  input  logic [bmef_pkg::POINT_W-1:0] cand_i,
  input  logic [bmef_pkg::POINT_W-1:0] last_i,
  input  logic [bmef_pkg::POINT_W-1:0] best_i,
  output bmef_pkg::cmp_res_t           res_o
);
  import bmef_pkg::*;

  always_comb begin
    res_o.subset     = ((ref_i & ~cand_i) == '0) && (ref_i != cand_i);
    res_o.above_last = cand_i > last_i;
    res_o.below_best = cand_i < best_i;
  end

endmodule

@@ rtl/core/bitset_maximal_element_filter.sv @@
// Flow: points load one per cycle until the marked point. Then the dominance
// pass compares each stored point with the store until a strict superset or
// the end, and each of the S distinct survivors costs one scan of the store
// (plus one final scan) and one output. Throughput is set by the single store
// read port. Input stalls from the marked point until the last result is taken.
// Reset: async, clears count, overflow flag, survivor marks and handshakes.
// ----------------------------------------------------------------------------
// bitset_maximal_element_filter
// Loads a set of bit vectors, drops strict subsets and duplicates, and
// emits the maximal points in ascending order.
// ----------------------------------------------------------------------------
module bitset_maximal_element_filter #(
  parameter int DIMS     = bmef_pkg::DIMS_DEF,
  parameter int CAPACITY = bmef_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmef_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmef_pkg::out_item_t out_item_o
);
  import bmef_pkg::*;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MASK_BITS = (DIMS >= POINT_W) ? POINT_W : DIMS;
  localparam logic [POINT_W-1:0] DimMask = {POINT_W{1'b1}} >> (POINT_W - MASK_BITS);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_AGET = 3'd2;
  localparam logic [2:0] S_BRD  = 3'd3;
  localparam logic [2:0] S_BCMP = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_ECMP = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [IDX_W-1:0]    i_q, i_d;
  logic [IDX_W-1:0]    j_q, j_d;
  logic [CAPACITY-1:0] dom_q, dom_d;
  logic                have_q, have_d;
  logic                found_q, found_d;
  logic                out_valid_q, out_valid_d;
  logic [POINT_W-1:0]  a_q, a_d;
  logic [POINT_W-1:0]  best_q, best_d;
  logic [POINT_W-1:0]  last_q, last_d;
  out_item_t           out_q, out_d;

  logic               in_acc;
  logic               room;
  logic [IDX_W-1:0]   raddr;
  logic [POINT_W-1:0] rdata;
  logic [CNT_W-1:0]   cnt_last;
  logic               i_end, j_end;
  logic               take, nf;
  logic [POINT_W-1:0] nb;
  cmp_res_t           cmp;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = cnt_q < CNT_W'(CAPACITY);
  assign cnt_last   = cnt_q - CNT_W'(1);
  assign i_end      = CNT_W'(i_q) == cnt_last;
  assign j_end      = CNT_W'(j_q) == cnt_last;

  assign raddr = (state_q == S_BRD) ? j_q : i_q;

  bmef_store #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && room),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (in_item_i.point & DimMask),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bmef_cmp u_cmp (
    .ref_i  (a_q),
    .cand_i (rdata),
    .last_i (last_q),
    .best_i (best_q),
    .res_o  (cmp)
  );

  // candidate qualifies: not dominated, above last survivor found (if any), below current best (if any)
  assign take = !dom_q[i_q] && (!have_q || cmp.above_last) && (!found_q || cmp.below_best);
  assign nf   = found_q || take;
  assign nb   = take ? rdata : best_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    dom_d       = dom_q;
    have_d      = have_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    best_d      = best_q;
    last_d      = last_q;
    out_d       = out_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_item_i.set_end) begin
            i_d     = '0;
            dom_d   = '0;
            state_d = S_ARD;
          end
        end
      end
      S_ARD: begin
        state_d = S_AGET;
      end
      S_AGET: begin
        a_d     = rdata;
        j_d     = '0;
        state_d = S_BRD;
      end
      S_BRD: begin
        state_d = S_BCMP;
      end
      S_BCMP: begin
        if (cmp.subset || j_end) begin
          if (cmp.subset) begin
            dom_d[i_q] = 1'b1;
          end
          if (i_end) begin
            i_d     = '0;
            have_d  = 1'b0;
            found_d = 1'b0;
            state_d = S_ERD;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_ARD;
          end
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = S_BRD;
        end
      end
      S_ERD: begin
        state_d = S_ECMP;
      end
      S_ECMP: begin
        if (!i_end) begin
          found_d = nf;
          best_d  = nb;
          i_d     = i_q + IDX_W'(1);
          state_d = S_ERD;
        end else if (nf && !have_q) begin
          // first survivor found; hold it until the next one is known
          last_d  = nb;
          have_d  = 1'b1;
          found_d = 1'b0;
          i_d     = '0;
          state_d = S_ERD;
        end else begin
          out_d.kept_point   = last_q;
          out_d.final_result = !nf;
          out_d.overflowed   = ovf_q;
          out_valid_d        = 1'b1;
          last_d             = nb;
          state_d            = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_q.final_result) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            have_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            i_d     = '0;
            found_d = 1'b0;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      dom_q       <= '0;
      have_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      dom_q       <= dom_d;
      have_q      <= have_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    best_q <= best_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_out_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OUT)
    else $error("result valid outside output state");

  a_ovf_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !room) |=> ovf_q)
    else $error("overflow not flagged on full store");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> cnt_q != '0)
    else $error("filter running on empty store");
`endif

endmodule
